// ----- src/etp_pkg.sv -----
// Package for the exclusive time profiler: widths, codes and state encoding.
package etp_pkg;

	// The timestamp and accumulator fields are fixed at 32 bits.
	localparam int TIME_BITS = 32;
	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	// Default sizes for the top-level parameters.
	localparam int NUM_FUNCS_DEF   = 64;
	localparam int STACK_DEPTH_DEF = 32;

	// Field widths on the streaming ports.
	localparam int REQ_W   = 2;
	localparam int ID_W    = 6;
	localparam int STAT_W  = 2;
	localparam int DEPTH_W = 6;
	localparam int IN_DW   = 40;
	localparam int OUT_DW  = 40;

	// Request codes carried in the input tuser.
	typedef enum logic [REQ_W-1:0] {
		REQ_START = 2'd0,
		REQ_END   = 2'd1,
		REQ_READ  = 2'd2,
		REQ_NONE  = 2'd3
	} req_t;

	// Status codes carried in the output tuser.
	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_OVERFLOW  = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_BACKWARD  = 2'd3
	} status_t;

	// Sequencer states.
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_TOP,
		S_ACC,
		S_OUT
	} state_t;

endpackage

// ----- src/exclusive_time_profiler_unit.sv -----
// Top level of the exclusive time profiler: call stack and accumulator memories with sequencer.
//
// The profiler takes trace items (start, end, read) on the slave stream and returns one result
// item per input item on the master stream. Each item passes through the sequencer steps in order: accept,
// which also reads the top of the call stack from its memory, read the accumulator from its
// memory, write back the credited total and the stack, then move the result into the output
// register once it is free. No new item is accepted until the last has moved there. The chain
// of two dependent synchronous memory reads sets this sequence. After reset the accumulator
// memory is cleared one entry per cycle, and no item is accepted during that pass. A new item
// may be accepted while the previous result still waits in the output register; the next
// result waits until that register is free.
module exclusive_time_profiler_unit #(
	parameter int NUM_FUNCS   = etp_pkg::NUM_FUNCS_DEF,
	parameter int STACK_DEPTH = etp_pkg::STACK_DEPTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// Input items.
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	// tdata from bit 0: func_id[5:0], timestamp[37:6], zero pad[39:38].
	input  logic [etp_pkg::IN_DW-1:0]   s_axis_tdata,
	// tuser: req_type[1:0].
	input  logic [etp_pkg::REQ_W-1:0]   s_axis_tuser,
	// Result items.
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	// tdata from bit 0: read_value[31:0], stack_depth[37:32], zero pad[39:38].
	output logic [etp_pkg::OUT_DW-1:0]  m_axis_tdata,
	// tuser: status[1:0].
	output logic [etp_pkg::STAT_W-1:0]  m_axis_tuser
);

	import etp_pkg::*;

	localparam int FW  = $clog2(NUM_FUNCS);
	localparam int SW  = $clog2(STACK_DEPTH);
	localparam int SPW = $clog2(STACK_DEPTH + 1);

	// Memories.
	logic [ID_W-1:0]      call_stack [STACK_DEPTH];
	logic [TIME_BITS-1:0] acc_mem    [NUM_FUNCS];

	// Sequencer and architectural state.
	state_t               state_q, state_d;
	logic [FW-1:0]        clr_q;
	logic [SPW-1:0]       sp_q;
	logic [TIME_BITS-1:0] resume_q;

	// Latched item and per-item decisions.
	req_t                 req_q;
	logic [ID_W-1:0]      id_q;
	logic [TIME_BITS-1:0] ts_q;
	logic [ID_W-1:0]      stack_rd_q;
	logic [TIME_BITS-1:0] acc_rd_q;
	logic [TIME_BITS:0]   inc_q;
	logic                 credit_q;
	logic                 push_q;
	logic                 pop_q;
	logic                 tgt_ok_q;
	logic [FW-1:0]        tgt_addr_q;
	status_t              status_q;

	// Output register.
	logic                 m_valid_q;
	logic [OUT_DW-1:0]    m_data_q;
	logic [STAT_W-1:0]    m_user_q;

	// Combinational signals.
	logic                 acc_we;
	logic [FW-1:0]        acc_wa;
	logic [TIME_BITS-1:0] acc_wd;
	logic                 accept;
	logic                 out_load;
	logic [ID_W-1:0]      tgt_id;
	logic [31:0]          tgt_ext;
	logic                 tgt_ok;
	logic                 full;
	logic                 empty;
	logic                 ts_lt;
	logic                 ts_back_end;
	logic [TIME_BITS+1:0] acc_sum;
	logic [TIME_BITS-1:0] acc_sat;
	logic [SPW-1:0]       sp_top;
	logic [31:0]          sp_ext;
	logic [TIME_BITS-1:0] out_value;
	logic [TIME_BITS:0]   inc_d;
	logic                 credit_d;
	logic                 push_d;
	logic                 pop_d;
	status_t              status_d;

	assign accept   = s_axis_tvalid && s_axis_tready;
	assign out_load = (state_q == S_OUT) && (!m_valid_q || m_axis_tready);

	// Decisions taken once the stack top is known.
	assign tgt_id      = (req_q == REQ_READ) ? id_q : stack_rd_q;
	assign tgt_ext     = 32'(tgt_id);
	assign tgt_ok      = tgt_ext < 32'(NUM_FUNCS);
	assign full        = 32'(sp_q) >= 32'(STACK_DEPTH);
	assign empty       = (sp_q == '0);
	assign ts_lt       = ts_q < resume_q;
	assign ts_back_end = ({1'b0, ts_q} + {{TIME_BITS{1'b0}}, 1'b1}) < {1'b0, resume_q};
	assign sp_top      = sp_q - SPW'(1);

	// Saturating accumulate.
	assign acc_sum = {2'b00, acc_rd_q} + {1'b0, inc_q};
	assign acc_sat = (acc_sum > {2'b00, TIME_MAX}) ? TIME_MAX : acc_sum[TIME_BITS-1:0];

	assign sp_ext    = 32'(sp_q);
	assign out_value = ((req_q == REQ_READ) && tgt_ok_q) ? acc_rd_q : '0;

	// Sequencer state register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and memory write controls.
	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		acc_we        = 1'b0;
		acc_wa        = tgt_addr_q;
		acc_wd        = acc_sat;
		case (state_q)
			S_CLEAR: begin
				acc_we = 1'b1;
				acc_wa = clr_q;
				acc_wd = '0;
				if (clr_q == FW'(NUM_FUNCS - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					state_d = S_TOP;
				end
			end
			S_TOP: begin
				state_d = S_ACC;
			end
			S_ACC: begin
				acc_we  = credit_q;
				state_d = S_OUT;
			end
			S_OUT: begin
				if (out_load) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Clearing pass counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (state_q == S_CLEAR) begin
			clr_q <= clr_q + FW'(1);
		end
	end

	// Call stack memory: the top entry is read every cycle, a push writes in the update step.
	always_ff @(posedge clk) begin
		stack_rd_q <= call_stack[sp_top[SW-1:0]];
		if (state_q == S_ACC && push_q) begin
			call_stack[sp_q[SW-1:0]] <= id_q;
		end
	end

	// Accumulator memory: read once per item, written by the clearing pass or a credit.
	always_ff @(posedge clk) begin
		if (state_q == S_TOP) begin
			acc_rd_q <= acc_mem[tgt_ext[FW-1:0]];
		end
		if (acc_we) begin
			acc_mem[acc_wa] <= acc_wd;
		end
	end

	// Item capture on acceptance.
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req_t'(s_axis_tuser);
			id_q  <= s_axis_tdata[ID_W-1:0];
			ts_q  <= s_axis_tdata[ID_W +: TIME_BITS];
		end
	end

	// Per-item decisions from the latched item and the stack top.
	always_comb begin
		inc_d    = '0;
		credit_d = 1'b0;
		push_d   = 1'b0;
		pop_d    = 1'b0;
		status_d = ST_OK;
		case (req_q)
			REQ_START: begin
				if (full) begin
					status_d = ST_OVERFLOW;
				end else begin
					push_d = 1'b1;
					if (ts_lt) begin
						status_d = ST_BACKWARD;
					end
					credit_d = !empty && !ts_lt && tgt_ok;
					inc_d    = {1'b0, ts_q - resume_q};
				end
			end
			REQ_END: begin
				if (empty) begin
					status_d = ST_UNDERFLOW;
				end else begin
					pop_d = 1'b1;
					if (ts_back_end) begin
						status_d = ST_BACKWARD;
					end
					credit_d = !ts_lt && tgt_ok;
					inc_d    = {1'b0, ts_q - resume_q} + {{TIME_BITS{1'b0}}, 1'b1};
				end
			end
			default: begin
			end
		endcase
	end

	// Per-item decisions, taken while the accumulator is being read.
	always_ff @(posedge clk) begin
		if (state_q == S_TOP) begin
			tgt_ok_q   <= tgt_ok;
			tgt_addr_q <= tgt_ext[FW-1:0];
			inc_q      <= inc_d;
			credit_q   <= credit_d;
			push_q     <= push_d;
			pop_q      <= pop_d;
			status_q   <= status_d;
		end
	end

	// Stack pointer and first uncredited tick.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q     <= '0;
			resume_q <= '0;
		end else if (state_q == S_ACC) begin
			if (push_q) begin
				sp_q     <= sp_q + SPW'(1);
				resume_q <= ts_q;
			end else if (pop_q) begin
				sp_q     <= sp_top;
				resume_q <= (ts_q == TIME_MAX) ? TIME_MAX : ts_q + TIME_BITS'(1);
			end
		end
	end

	// Output register: loaded when free, cleared when taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_data_q <= {2'b00, sp_ext[DEPTH_W-1:0], out_value};
			m_user_q <= status_q;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tuser  = m_user_q;

endmodule
